/* sv/psp_pkg.sv */
package psp_pkg;

    localparam int CMD_WIDTH   = 3;
    localparam int COUNT_WIDTH = 32;
    localparam int IV_WIDTH    = 32;
    localparam int GRAN_WIDTH  = 32;
    localparam int BURST_WIDTH = 8;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int CFG_IDX_BIT = 2;

    localparam logic [GRAN_WIDTH-1:0]  GRAN_RESET  = 32'd1000;
    localparam logic [BURST_WIDTH-1:0] BURST_RESET = 8'd10;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK_IN  = 3'd0,
        CMD_TICK_OUT = 3'd1,
        CMD_QUERY    = 3'd2,
        CMD_SENT     = 3'd3,
        CMD_LOSS     = 3'd4
    } cmd_t;

    typedef enum logic {
        REG_GRAN  = 1'b0,
        REG_BURST = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic sent_since_tick;
        logic delayed_mark;
        logic delayed_at_tick;
    } flags_t;

endpackage

/* sv/psp_cfg.sv */
module psp_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psp_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [psp_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [psp_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                pready,
    output logic [psp_pkg::GRAN_WIDTH-1:0]      gran,
    output logic [psp_pkg::BURST_WIDTH-1:0]     burst
);
    import psp_pkg::*;

    logic [GRAN_WIDTH-1:0]  gran_reg;
    logic [BURST_WIDTH-1:0] burst_reg;
    logic                   wr_en;
    reg_idx_t               idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_IDX_BIT]);
    assign pready = 1'b1;
    assign gran   = gran_reg;
    assign burst  = burst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gran_reg  <= GRAN_RESET;
            burst_reg <= BURST_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GRAN:  gran_reg  <= pwdata[GRAN_WIDTH-1:0];
                REG_BURST: burst_reg <= pwdata[BURST_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GRAN:  prdata = PDATA_WIDTH'(gran_reg);
            REG_BURST: prdata = PDATA_WIDTH'(burst_reg);
            default:   prdata = '0;
        endcase
    end

endmodule

/* sv/psp_step.sv */
module psp_step #(
    parameter int TW = 64
) (
    input  logic [psp_pkg::CMD_WIDTH-1:0]   cmd,
    input  logic [TW-1:0]                   now,
    input  logic [psp_pkg::COUNT_WIDTH-1:0] inflight,
    input  logic                            recovery,
    input  logic [psp_pkg::IV_WIDTH-1:0]    iv,
    input  logic [psp_pkg::GRAN_WIDTH-1:0]  gran,
    input  logic [psp_pkg::BURST_WIDTH-1:0] burst,
    input  psp_pkg::flags_t                 flags,
    input  logic [psp_pkg::BURST_WIDTH-1:0] tokens,
    input  logic [TW-1:0]                   pace_time,
    input  logic [TW-1:0]                   last_delay,
    input  logic [TW-1:0]                   clock_now,
    output psp_pkg::flags_t                 flags_next,
    output logic [psp_pkg::BURST_WIDTH-1:0] tokens_next,
    output logic [TW-1:0]                   pace_time_next,
    output logic [TW-1:0]                   last_delay_next,
    output logic [TW-1:0]                   clock_next,
    output logic                            may
);
    import psp_pkg::*;

    logic [IV_WIDTH-1:0]    iv_eff;
    logic [TW:0]            iv_ext;
    logic [TW:0]            clk_plus_iv;
    logic [TW:0]            next_plus_iv;
    logic [TW:0]            last_plus_iv;
    logic [TW-1:0]          nt_delayed;
    logic [TW-1:0]          ahead;
    logic [BURST_WIDTH-1:0] tok_fill;
    logic                   late;

    assign iv_eff       = (iv == '0) ? IV_WIDTH'(1) : iv;
    assign iv_ext       = (TW+1)'(iv_eff);
    assign clk_plus_iv  = {1'b0, clock_now} + iv_ext;
    assign next_plus_iv = {1'b0, pace_time} + iv_ext;
    assign last_plus_iv = {1'b0, last_delay} + iv_ext;
    assign nt_delayed   = next_plus_iv[TW] ? {TW{1'b1}} : next_plus_iv[TW-1:0];
    assign ahead        = pace_time - clock_now;
    assign tok_fill     = (inflight == '0 && !recovery) ? burst : tokens;
    assign late         = (nt_delayed <= clock_now)
                       || (last_delay != '0 && !(last_plus_iv > {1'b0, clock_now}));

    always_comb
    begin
        flags_next      = flags;
        tokens_next     = tokens;
        pace_time_next  = pace_time;
        last_delay_next = last_delay;
        clock_next      = clock_now;
        may             = 1'b0;
        case (cmd_t'(cmd))
            CMD_TICK_IN:
            begin
                if (now > clock_now)
                    clock_next = now;
                if (flags.delayed_mark)
                    flags_next.delayed_at_tick = 1'b1;
                flags_next.sent_since_tick = 1'b0;
            end
            CMD_TICK_OUT:
            begin
                if (flags.delayed_at_tick && !flags.sent_since_tick && clock_now > pace_time)
                    flags_next.delayed_mark = 1'b0;
                flags_next.delayed_at_tick = 1'b0;
            end
            CMD_QUERY:
            begin
                may = 1'b1;
                if (tokens == '0 && inflight != '0 && pace_time > clock_now
                    && ahead > TW'(gran))
                begin
                    flags_next.delayed_mark = 1'b1;
                    may = 1'b0;
                end
            end
            CMD_SENT:
            begin
                flags_next.sent_since_tick = 1'b1;
                tokens_next = tok_fill;
                if (tok_fill != '0)
                begin
                    tokens_next             = tok_fill - BURST_WIDTH'(1);
                    flags_next.delayed_mark = 1'b0;
                    pace_time_next          = '0;
                    last_delay_next         = '0;
                end
                else if (flags.delayed_mark)
                begin
                    pace_time_next = nt_delayed;
                    if (late)
                        last_delay_next = clock_now;
                    else
                    begin
                        flags_next.delayed_mark = 1'b0;
                        last_delay_next         = '0;
                    end
                end
                else if (clk_plus_iv[TW] || next_plus_iv[TW])
                    pace_time_next = {TW{1'b1}};
                else if (next_plus_iv > clk_plus_iv)
                    pace_time_next = next_plus_iv[TW-1:0];
                else
                    pace_time_next = clk_plus_iv[TW-1:0];
            end
            CMD_LOSS:
                tokens_next = '0;
            default: ;
        endcase
    end

endmodule

/* sv/packet_send_pacer_unit.sv */
// pipeline: 2 register stages, the input register and then the result register,
// which an accepted transaction passes through in that order
// throughput: one transaction per cycle unless stalled, a single pass per item
// the input register holds while the output register is full and not taken
// reset: asynchronous active low, clears valids, flags and times to zero,
// granularity to 1000, burst size and burst tokens to 10
module packet_send_pacer_unit #(
    parameter int TIME_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psp_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [psp_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [psp_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [psp_pkg::CMD_WIDTH-1:0]   cmd,
    input  logic [TIME_WIDTH-1:0]           now_time,
    input  logic [psp_pkg::COUNT_WIDTH-1:0] inflight_count,
    input  logic                            loss_recovery,
    input  logic [psp_pkg::IV_WIDTH-1:0]    send_interval,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            may_send,
    output logic                            is_delayed,
    output logic [TIME_WIDTH-1:0]           next_send_time
);
    import psp_pkg::*;

    logic [GRAN_WIDTH-1:0]  gran;
    logic [BURST_WIDTH-1:0] burst;

    logic                   in_v_reg;
    logic [CMD_WIDTH-1:0]   cmd_reg;
    logic [TIME_WIDTH-1:0]  now_reg;
    logic [COUNT_WIDTH-1:0] inflight_reg;
    logic                   rec_reg;
    logic [IV_WIDTH-1:0]    iv_reg;

    flags_t                 flags_reg;
    flags_t                 flags_next;
    logic [BURST_WIDTH-1:0] tokens_reg;
    logic [BURST_WIDTH-1:0] tokens_next;
    logic [TIME_WIDTH-1:0]  pace_time_reg;
    logic [TIME_WIDTH-1:0]  pace_time_next;
    logic [TIME_WIDTH-1:0]  last_delay_reg;
    logic [TIME_WIDTH-1:0]  last_delay_next;
    logic [TIME_WIDTH-1:0]  clock_reg;
    logic [TIME_WIDTH-1:0]  clock_next;
    logic                   may_next;

    logic                   out_v_reg;
    logic                   may_reg;
    logic                   dly_reg;
    logic [TIME_WIDTH-1:0]  nst_reg;

    logic                   in_accept;
    logic                   advance;

    psp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gran    (gran),
        .burst   (burst)
    );

    psp_step #(
        .TW (TIME_WIDTH)
    ) u_step (
        .cmd             (cmd_reg),
        .now             (now_reg),
        .inflight        (inflight_reg),
        .recovery        (rec_reg),
        .iv              (iv_reg),
        .gran            (gran),
        .burst           (burst),
        .flags           (flags_reg),
        .tokens          (tokens_reg),
        .pace_time       (pace_time_reg),
        .last_delay      (last_delay_reg),
        .clock_now       (clock_reg),
        .flags_next      (flags_next),
        .tokens_next     (tokens_next),
        .pace_time_next  (pace_time_next),
        .last_delay_next (last_delay_next),
        .clock_next      (clock_next),
        .may             (may_next)
    );

    assign advance   = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || advance;
    assign in_accept = in_valid && in_ready;

    assign out_valid      = out_v_reg;
    assign may_send       = may_reg;
    assign is_delayed     = dly_reg;
    assign next_send_time = nst_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_accept)
            in_v_reg <= 1'b1;
        else if (advance)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd;
            now_reg      <= now_time;
            inflight_reg <= inflight_count;
            rec_reg      <= loss_recovery;
            iv_reg       <= send_interval;
        end
    end

    // pacer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            tokens_reg     <= BURST_RESET;
            pace_time_reg  <= '0;
            last_delay_reg <= '0;
            clock_reg      <= '0;
        end
        else if (advance)
        begin
            flags_reg      <= flags_next;
            tokens_reg     <= tokens_next;
            pace_time_reg  <= pace_time_next;
            last_delay_reg <= last_delay_next;
            clock_reg      <= clock_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= 1'b1;
        else if (out_ready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            may_reg <= may_next;
            dly_reg <= flags_next.delayed_mark;
            nst_reg <= pace_time_next;
        end
    end

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> clock_reg >= $past(clock_reg))
        else $error("pacer clock moved backward");

    a_loss_empties: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd_reg == CMD_LOSS |=> tokens_reg == '0)
        else $error("loss transaction left burst tokens");

    a_may_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd_reg != CMD_QUERY |=> !may_reg)
        else $error("may_send raised outside a can-send query");

    a_delayed_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> dly_reg == flags_reg.delayed_mark && nst_reg == pace_time_reg)
        else $error("result does not match pacer state");

endmodule
